### sv/cln_pkg.sv
// Shared types, codes, constants and helper functions of the character LCD nibble formatter.
`timescale 1ns / 1ps

package cln_pkg;

	typedef enum logic [2:0] {
		CMD_BYTE  = 3'd0,
		CMD_CHAR  = 3'd1,
		CMD_HEX8  = 3'd2,
		CMD_HEX16 = 3'd3,
		CMD_DEC   = 3'd4,
		CMD_INIT  = 3'd5
	} cmd_t;

	localparam logic [7:0] LCD_DISP_ON   = 8'h0c;
	localparam logic [7:0] LCD_CMD_CLR   = 8'h01;
	localparam logic [7:0] LCD_INIT_A    = 8'h33;
	localparam logic [7:0] LCD_INIT_B    = 8'h32;
	localparam logic [7:0] CHR_PLUS      = 8'h2b;
	localparam logic [7:0] CHR_MINUS     = 8'h2d;
	localparam logic [7:0] CHR_ZERO      = 8'h30;
	localparam logic [7:0] CHR_HEX_ALPHA = 8'h37;
	localparam logic [31:0] DIV10_RECIP  = 32'd52429;
	localparam int DIV10_SHIFT           = 19;
	localparam int MAX_BYTES             = 6;

	// Payload that travels down the decimal pipeline.
	typedef struct packed {
		logic [2:0]       cmd;
		logic [15:0]      value;
		logic             neg;
		logic [15:0]      rem;
		logic [3:0][3:0]  digs;
	} pipe_t;

	// One decimal step: quotient and remainder of x / 10 by reciprocal multiply.
	function automatic logic [19:0] div10_step(input logic [15:0] x);
		logic [31:0] prod;
		logic [15:0] q;
		logic [15:0] r;
		prod = {16'b0, x} * DIV10_RECIP;
		q = {3'b0, prod[31:DIV10_SHIFT]};
		r = x - ((q << 3) + (q << 1));
		return {q, r[3:0]};
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		return (d < 4'd10) ? (CHR_ZERO + {4'b0, d}) : (CHR_HEX_ALPHA + {4'b0, d});
	endfunction

endpackage

### sv/cln_decode.sv
// Input stage: registers the request and forms the sign and magnitude of the decimal operand.
`timescale 1ns / 1ps

module cln_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [2:0]      in_cmd,
	input  logic [15:0]     in_value,
	output logic            out_valid,
	input  logic            out_ready,
	output cln_pkg::pipe_t  out_data
);
	import cln_pkg::*;

	logic  valid_s1;
	pipe_t data_s1;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.cmd   <= in_cmd;
			data_s1.value <= in_value;
			data_s1.neg   <= in_value[15];
			data_s1.rem   <= in_value[15] ? (~in_value + 16'd1) : in_value;
			data_s1.digs  <= '0;
		end
	end

endmodule

### sv/cln_bcd_pipe.sv
// Four pipeline stages that peel one decimal digit each off the magnitude.
`timescale 1ns / 1ps

module cln_bcd_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cln_pkg::pipe_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output cln_pkg::pipe_t  out_data
);
	import cln_pkg::*;

	logic  valid_s2, valid_s3, valid_s4, valid_s5;
	pipe_t data_s2, data_s3, data_s4, data_s5;
	pipe_t nxt_s2, nxt_s3, nxt_s4, nxt_s5;
	logic  rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic [19:0] st_s2, st_s3, st_s4, st_s5;

	assign rdy_s5 = !valid_s5 || out_ready;
	assign rdy_s4 = !valid_s4 || rdy_s5;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign in_ready  = rdy_s2;
	assign out_valid = valid_s5;
	assign out_data  = data_s5;

	assign st_s2 = div10_step(in_data.rem);
	assign st_s3 = div10_step(data_s2.rem);
	assign st_s4 = div10_step(data_s3.rem);
	assign st_s5 = div10_step(data_s4.rem);

	// Digits shift in at the low end, so the units digit ends up in the top slot.
	always_comb begin
		nxt_s2      = in_data;
		nxt_s2.rem  = st_s2[19:4];
		nxt_s2.digs = {in_data.digs[2:0], st_s2[3:0]};
		nxt_s3      = data_s2;
		nxt_s3.rem  = st_s3[19:4];
		nxt_s3.digs = {data_s2.digs[2:0], st_s3[3:0]};
		nxt_s4      = data_s3;
		nxt_s4.rem  = st_s4[19:4];
		nxt_s4.digs = {data_s3.digs[2:0], st_s4[3:0]};
		nxt_s5      = data_s4;
		nxt_s5.rem  = st_s5[19:4];
		nxt_s5.digs = {data_s4.digs[2:0], st_s5[3:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s2) valid_s2 <= in_valid;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			data_s2 <= nxt_s2;
		end
		if (rdy_s3 && valid_s2) begin
			data_s3 <= nxt_s3;
		end
		if (rdy_s4 && valid_s3) begin
			data_s4 <= nxt_s4;
		end
		if (rdy_s5 && valid_s4) begin
			data_s5 <= nxt_s5;
		end
	end

`ifndef SYNTHESIS
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rdy_s3 |=> valid_s2 && $stable(data_s2))
		else $error("stage 2 item lost during stall");
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !out_ready |=> valid_s5 && $stable(data_s5))
		else $error("stage 5 item lost during stall");
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> data_s3.digs[0] < 4'd10)
		else $error("decimal digit out of range");
`endif

endmodule

### sv/cln_serializer.sv
// Builds the byte record of a request and sends it out one nibble per cycle while out_ready is high.
`timescale 1ns / 1ps

module cln_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cln_pkg::pipe_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [3:0]      out_nibble,
	output logic            out_rs,
	output logic            out_last
);
	import cln_pkg::*;

	logic [MAX_BYTES-1:0][7:0] bytes_d, bytes_q;
	logic [2:0] nbytes_d;
	logic       rs_d, rs_q;
	logic       busy_q;
	logic [3:0] idx_q, lastidx_q;
	logic       at_last;
	logic [2:0] byte_sel;

	always_comb begin
		bytes_d  = '0;
		nbytes_d = 3'd0;
		rs_d     = 1'b1;
		case (in_data.cmd)
			CMD_BYTE: begin
				bytes_d[0] = in_data.value[7:0];
				nbytes_d   = 3'd1;
				rs_d       = 1'b0;
			end
			CMD_CHAR: begin
				bytes_d[0] = in_data.value[7:0];
				nbytes_d   = 3'd1;
			end
			CMD_HEX8: begin
				bytes_d[0] = hex_char(in_data.value[7:4]);
				bytes_d[1] = hex_char(in_data.value[3:0]);
				nbytes_d   = 3'd2;
			end
			CMD_HEX16: begin
				bytes_d[0] = hex_char(in_data.value[15:12]);
				bytes_d[1] = hex_char(in_data.value[11:8]);
				bytes_d[2] = hex_char(in_data.value[7:4]);
				bytes_d[3] = hex_char(in_data.value[3:0]);
				nbytes_d   = 3'd4;
			end
			CMD_DEC: begin
				bytes_d[0] = in_data.neg ? CHR_MINUS : CHR_PLUS;
				bytes_d[1] = CHR_ZERO + {4'b0, in_data.rem[3:0]};
				bytes_d[2] = CHR_ZERO + {4'b0, in_data.digs[0]};
				bytes_d[3] = CHR_ZERO + {4'b0, in_data.digs[1]};
				bytes_d[4] = CHR_ZERO + {4'b0, in_data.digs[2]};
				bytes_d[5] = CHR_ZERO + {4'b0, in_data.digs[3]};
				nbytes_d   = 3'd6;
			end
			CMD_INIT: begin
				bytes_d[0] = LCD_INIT_A;
				bytes_d[1] = LCD_INIT_B;
				bytes_d[2] = LCD_DISP_ON;
				bytes_d[3] = LCD_CMD_CLR;
				nbytes_d   = 3'd4;
				rs_d       = 1'b0;
			end
			default: begin
				nbytes_d = 3'd0;
			end
		endcase
	end

	assign at_last   = (idx_q == lastidx_q);
	assign in_ready  = !busy_q || (out_ready && at_last);
	assign byte_sel  = idx_q[3:1];
	assign out_valid = busy_q;
	assign out_nibble = idx_q[0] ? bytes_q[byte_sel][3:0] : bytes_q[byte_sel][7:4];
	assign out_rs    = rs_q;
	assign out_last  = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= 4'd0;
			lastidx_q <= 4'd0;
		end else if (in_valid && in_ready) begin
			busy_q    <= (nbytes_d != 3'd0);
			idx_q     <= 4'd0;
			lastidx_q <= {nbytes_d, 1'b0} - 4'd1;
		end else if (busy_q && out_ready) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bytes_q <= bytes_d;
			rs_q    <= rs_d;
		end
	end

`ifndef SYNTHESIS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= lastidx_q)
		else $error("nibble index past end of record");
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && out_ready && !at_last |=> busy_q && idx_q == $past(idx_q) + 4'd1)
		else $error("run ended before its last nibble");
	a_even_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> lastidx_q[0])
		else $error("run length is not a whole number of bytes");
`endif

endmodule

### sv/char_lcd_nibble_formatter.sv
// Top level of the character LCD nibble formatter: decode, decimal pipeline and serializer.
`timescale 1ns / 1ps

// Usage:
// A request enters on the slave stream (s_tvalid/s_tready) with its command code on s_tuser
// and its operand on s_tdata. It is expanded into 4-bit bus writes on the master stream
// (m_tvalid/m_tready/m_tdata/m_tuser/m_tlast), upper nibble of each byte first; m_tuser
// carries the register select. Run lengths in nibbles are: raw command 2, raw character 2,
// hex byte 4, hex word 8, signed decimal 12, init sequence 8. Unused command codes produce
// no write. m_tlast marks the final nibble of each request's run.
// Path: a request that is accepted passes one decode stage and four decimal digit stages
// and is then loaded into the serializer, which presents its first nibble. Each digit stage
// holds one 16x16 reciprocal multiply.
// Throughput: while m_tready is high the serializer sends one nibble per cycle and loads the
// next request in the same cycle as the last nibble goes out, so runs follow without gaps.
// Up to five requests wait in the pipeline behind the one being sent.
// Reset (arst_n low) clears all valid bits at once; no item is pending afterwards.
// When the receiver holds m_tready low, the current nibble stays on the port and every
// stage upstream holds its item, so nothing is lost or repeated.

module char_lcd_nibble_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] value
	input  logic [2:0]  s_tuser,   // [2:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [3:0] nibble, [7:4] zero
	output logic        m_tuser,   // [0] reg_select
	output logic        m_tlast
);
	import cln_pkg::*;

	logic  dec_valid, dec_ready;
	pipe_t dec_data;
	logic  bcd_valid, bcd_ready;
	pipe_t bcd_data;
	logic [3:0] nibble;

	cln_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_value  (s_tdata),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.out_data  (dec_data)
	);

	cln_bcd_pipe u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_data   (dec_data),
		.out_valid (bcd_valid),
		.out_ready (bcd_ready),
		.out_data  (bcd_data)
	);

	cln_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (bcd_valid),
		.in_ready   (bcd_ready),
		.in_data    (bcd_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_nibble (nibble),
		.out_rs     (m_tuser),
		.out_last   (m_tlast)
	);

	assign m_tdata = {4'b0000, nibble};

endmodule
